FILE: design/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion converter.
package rmq_pkg;

	localparam int NUM_LANES = 3;

	typedef enum logic [1:0] {
		COMP_W = 2'd0,
		COMP_X = 2'd1,
		COMP_Y = 2'd2,
		COMP_Z = 2'd3
	} comp_t;

endpackage

FILE: design/rmq_sqrt_cell.sv
// One square root cell that settles one root bit per clock while enabled and passes its side data along.
module rmq_sqrt_cell #(
	parameter int W  = 16,
	parameter int SW = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              feed_valid,
	input  logic [2*W-1:0]    feed_rad,
	input  logic [W+1:0]      feed_rem,
	input  logic [W-1:0]      feed_root,
	input  logic [SW-1:0]     feed_side,
	output logic              valid,
	output logic [2*W-1:0]    rad,
	output logic [W+1:0]      rem,
	output logic [W-1:0]      root,
	output logic [SW-1:0]     side
);

	logic [W+3:0] cand;
	logic [W+3:0] trial;
	logic [W+3:0] diff;
	logic         ge;
	logic [W+1:0] next_rem;

	always_comb begin
		cand     = {feed_rem, feed_rad[2*W-1 -: 2]};
		trial    = (W+4)'({feed_root, 2'b01});
		diff     = cand - trial;
		ge       = (cand >= trial);
		next_rem = ge ? diff[W+1:0] : cand[W+1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b0;
		end else if (en) begin
			valid <= feed_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad  <= {feed_rad[2*W-3:0], 2'b00};
			rem  <= next_rem;
			root <= {feed_root[W-2:0], ge};
			side <= feed_side;
		end
	end

endmodule

FILE: design/rmq_div_cell.sv
// One divider cell that settles one quotient bit per clock in each lane while enabled.
module rmq_div_cell #(
	parameter int W  = 16,
	parameter int SW = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           feed_valid,
	input  logic [W:0]     feed_div,
	input  logic [2*W-1:0] feed_num [rmq_pkg::NUM_LANES],
	input  logic [W:0]     feed_rem [rmq_pkg::NUM_LANES],
	input  logic [2*W-1:0] feed_quo [rmq_pkg::NUM_LANES],
	input  logic [SW-1:0]  feed_side,
	output logic           valid,
	output logic [W:0]     div,
	output logic [2*W-1:0] num [rmq_pkg::NUM_LANES],
	output logic [W:0]     rem [rmq_pkg::NUM_LANES],
	output logic [2*W-1:0] quo [rmq_pkg::NUM_LANES],
	output logic [SW-1:0]  side
);

	logic [W+1:0] part [rmq_pkg::NUM_LANES];
	logic [W+1:0] diff [rmq_pkg::NUM_LANES];
	logic         ge   [rmq_pkg::NUM_LANES];
	logic [W:0]   next_rem [rmq_pkg::NUM_LANES];

	always_comb begin
		for (int l = 0; l < rmq_pkg::NUM_LANES; l++) begin
			part[l]     = {feed_rem[l], feed_num[l][2*W-1]};
			diff[l]     = part[l] - (W+2)'(feed_div);
			ge[l]       = (part[l] >= (W+2)'(feed_div));
			next_rem[l] = ge[l] ? diff[l][W:0] : part[l][W:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b0;
		end else if (en) begin
			valid <= feed_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div  <= feed_div;
			side <= feed_side;
			for (int l = 0; l < rmq_pkg::NUM_LANES; l++) begin
				num[l] <= {feed_num[l][2*W-2:0], 1'b0};
				rem[l] <= next_rem[l];
				quo[l] <= {feed_quo[l][2*W-2:0], ge[l]};
			end
		end
	end

endmodule

FILE: design/rotation_matrix_to_quaternion.sv
// Top level of the rotation matrix to quaternion converter.
// Converts a 3x3 rotation matrix in signed Q1.(DATA_WIDTH-2) to a unit quaternion by
// Shoemake's method, taking one matrix per clock while the output is not stalled. A
// chain of DATA_WIDTH square root cells settles one root bit each, a chain of
// 2*DATA_WIDTH divider cells settles one quotient bit each in three lanes, and an
// output register holds the result. The whole pipeline stalls while a result waits.
module rotation_matrix_to_quaternion #(
	parameter int DATA_WIDTH = 16
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       s_tvalid,
	output logic                                       s_tready,
	// m00, m01, m02, m10, m11, m12, m20, m21, m22 from the lowest bit up.
	input  logic [((9 * DATA_WIDTH + 7) / 8) * 8-1:0]  s_tdata,
	output logic                                       m_tvalid,
	input  logic                                       m_tready,
	// quat_w, quat_x, quat_y, quat_z from the lowest bit up.
	output logic [((4 * DATA_WIDTH + 7) / 8) * 8-1:0]  m_tdata
);

	localparam int W        = DATA_WIDTH;
	localparam int F        = DATA_WIDTH - 2;
	localparam int IN_BITS  = ((9 * DATA_WIDTH + 7) / 8) * 8;
	localparam int OUT_BITS = ((4 * DATA_WIDTH + 7) / 8) * 8;
	localparam int NL       = rmq_pkg::NUM_LANES;
	localparam int SSW      = NL * (W + 1) + NL + 2;
	localparam int DSW      = W + 2 + NL + 1;
	localparam int DSTEPS   = 2 * W;
	localparam logic signed [W+2:0] ONE_X = (W+3)'(1) << F;
	localparam logic [W-1:0]        ONE_W = W'(1) << F;

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	logic signed [W-1:0] m [9];
	always_comb begin
		for (int e = 0; e < 9; e++) begin
			m[e] = s_tdata[e*W +: W];
		end
	end

	logic signed [W+2:0] mx [9];
	logic signed [W+2:0] tr;
	logic signed [W+2:0] arg;
	logic signed [W:0]   d [NL];
	logic [W:0]          mag [NL];
	logic [NL-1:0]       neg;
	logic [W+1:0]        arg_c;
	rmq_pkg::comp_t      hsel;

	always_comb begin
		for (int e = 0; e < 9; e++) begin
			mx[e] = (W+3)'(m[e]);
		end
		tr = mx[0] + mx[4] + mx[8];
		if (tr > 0) begin
			hsel = rmq_pkg::COMP_W;
			arg  = tr + ONE_X;
			d[0] = (W+1)'(mx[7] - mx[5]);
			d[1] = (W+1)'(mx[2] - mx[6]);
			d[2] = (W+1)'(mx[3] - mx[1]);
		end else if (m[8] > m[4] && m[8] > m[0]) begin
			hsel = rmq_pkg::COMP_Z;
			arg  = mx[8] - (mx[0] + mx[4]) + ONE_X;
			d[0] = (W+1)'(mx[3] - mx[1]);
			d[1] = (W+1)'(mx[6] + mx[2]);
			d[2] = (W+1)'(mx[7] + mx[5]);
		end else if (m[4] > m[0]) begin
			hsel = rmq_pkg::COMP_Y;
			arg  = mx[4] - (mx[8] + mx[0]) + ONE_X;
			d[0] = (W+1)'(mx[2] - mx[6]);
			d[1] = (W+1)'(mx[3] + mx[1]);
			d[2] = (W+1)'(mx[5] + mx[7]);
		end else begin
			hsel = rmq_pkg::COMP_X;
			arg  = mx[0] - (mx[4] + mx[8]) + ONE_X;
			d[0] = (W+1)'(mx[7] - mx[5]);
			d[1] = (W+1)'(mx[1] + mx[3]);
			d[2] = (W+1)'(mx[2] + mx[6]);
		end
		arg_c = (arg > 0) ? arg[W+1:0] : '0;
		for (int l = 0; l < NL; l++) begin
			neg[l] = d[l][W];
			mag[l] = neg[l] ? (W+1)'(-d[l]) : (W+1)'(d[l]);
		end
	end

	logic           sq_valid [W+1];
	logic [2*W-1:0] sq_rad   [W+1];
	logic [W+1:0]   sq_rem   [W+1];
	logic [W-1:0]   sq_root  [W+1];
	logic [SSW-1:0] sq_side  [W+1];

	assign sq_valid[0] = s_tvalid;
	assign sq_rad[0]   = (2*W)'(arg_c) << F;
	assign sq_rem[0]   = '0;
	assign sq_root[0]  = '0;
	assign sq_side[0]  = {hsel, neg, mag[2], mag[1], mag[0]};

	for (genvar c = 0; c < W; c++) begin : g_sqrt
		rmq_sqrt_cell #(.W(W), .SW(SSW)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (en),
			.feed_valid (sq_valid[c]),
			.feed_rad   (sq_rad[c]),
			.feed_rem   (sq_rem[c]),
			.feed_root  (sq_root[c]),
			.feed_side  (sq_side[c]),
			.valid      (sq_valid[c+1]),
			.rad        (sq_rad[c+1]),
			.rem        (sq_rem[c+1]),
			.root       (sq_root[c+1]),
			.side       (sq_side[c+1])
		);
	end

	logic [W-1:0]   root_f;
	logic [W-1:0]   half;
	logic [W:0]     mag_f [NL];
	logic [NL-1:0]  neg_f;
	logic [1:0]     hsel_f;

	always_comb begin
		root_f = sq_root[W];
		for (int l = 0; l < NL; l++) begin
			mag_f[l] = sq_side[W][l*(W+1) +: (W+1)];
		end
		neg_f  = sq_side[W][NL*(W+1) +: NL];
		hsel_f = sq_side[W][NL*(W+1)+NL +: 2];
		half   = ((root_f >> 1) > ONE_W) ? ONE_W : (root_f >> 1);
	end

	logic           dv_valid [DSTEPS+1];
	logic [W:0]     dv_div   [DSTEPS+1];
	logic [2*W-1:0] dv_num   [DSTEPS+1][NL];
	logic [W:0]     dv_rem   [DSTEPS+1][NL];
	logic [2*W-1:0] dv_quo   [DSTEPS+1][NL];
	logic [DSW-1:0] dv_side  [DSTEPS+1];

	assign dv_valid[0] = sq_valid[W];
	assign dv_div[0]   = {root_f, 1'b0};
	assign dv_side[0]  = {(root_f == '0), neg_f, hsel_f, half};
	for (genvar l = 0; l < NL; l++) begin : g_lane_in
		assign dv_num[0][l] = ((2*W)'(mag_f[l]) << F) + (2*W)'(root_f);
		assign dv_rem[0][l] = '0;
		assign dv_quo[0][l] = '0;
	end

	for (genvar c = 0; c < DSTEPS; c++) begin : g_div
		rmq_div_cell #(.W(W), .SW(DSW)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (en),
			.feed_valid (dv_valid[c]),
			.feed_div   (dv_div[c]),
			.feed_num   (dv_num[c]),
			.feed_rem   (dv_rem[c]),
			.feed_quo   (dv_quo[c]),
			.feed_side  (dv_side[c]),
			.valid      (dv_valid[c+1]),
			.div        (dv_div[c+1]),
			.num        (dv_num[c+1]),
			.rem        (dv_rem[c+1]),
			.quo        (dv_quo[c+1]),
			.side       (dv_side[c+1])
		);
	end

	logic [W-1:0]   half_e;
	rmq_pkg::comp_t hsel_e;
	logic [NL-1:0]  neg_e;
	logic           zero_e;
	logic [W-1:0]   sat  [NL];
	logic [W-1:0]   lane [NL];
	logic [W-1:0]   comp [4];

	always_comb begin
		half_e = dv_side[DSTEPS][W-1:0];
		hsel_e = rmq_pkg::comp_t'(dv_side[DSTEPS][W +: 2]);
		neg_e  = dv_side[DSTEPS][W+2 +: NL];
		zero_e = dv_side[DSTEPS][W+2+NL];
		for (int l = 0; l < NL; l++) begin
			sat[l]  = (dv_quo[DSTEPS][l] > (2*W)'(ONE_W)) ? ONE_W
				: dv_quo[DSTEPS][l][W-1:0];
			lane[l] = zero_e ? '0 : (neg_e[l] ? W'(-sat[l]) : sat[l]);
		end
		for (int c = 0; c < 4; c++) begin
			if (2'(c) == hsel_e) begin
				comp[c] = half_e;
			end else if (2'(c) < hsel_e) begin
				comp[c] = lane[(c < NL) ? c : NL-1];
			end else begin
				comp[c] = lane[(c > 0) ? c-1 : 0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= dv_valid[DSTEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en && dv_valid[DSTEPS]) begin
			m_tdata <= OUT_BITS'({comp[3], comp[2], comp[1], comp[0]});
		end
	end

endmodule

FILE: design/rmq_checker.sv
// Port-level assertions for the rotation matrix to quaternion converter.
module rmq_checker #(
	parameter int DATA_WIDTH = 16
) (
	input logic                                      clk,
	input logic                                      arst_n,
	input logic                                      s_tvalid,
	input logic                                      s_tready,
	input logic [((9 * DATA_WIDTH + 7) / 8) * 8-1:0] s_tdata,
	input logic                                      m_tvalid,
	input logic                                      m_tready,
	input logic [((4 * DATA_WIDTH + 7) / 8) * 8-1:0] m_tdata
);

	localparam logic signed [DATA_WIDTH-1:0] ONE = DATA_WIDTH'(1) << (DATA_WIDTH - 2);

	logic in_range;
	always_comb begin
		in_range = 1'b1;
		for (int c = 0; c < 4; c++) begin
			if ($signed(m_tdata[c*DATA_WIDTH +: DATA_WIDTH]) > ONE
				|| $signed(m_tdata[c*DATA_WIDTH +: DATA_WIDTH]) < -ONE) begin
				in_range = 1'b0;
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("Result dropped while stalled.");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("Result changed while stalled.");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("Input refused with an empty output register.");

	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("Input taken while the pipeline is stalled.");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> in_range)
		else $error("Quaternion component outside plus or minus one.");

endmodule

bind rotation_matrix_to_quaternion rmq_checker #(.DATA_WIDTH(DATA_WIDTH)) u_rmq_checker (.*);
